// ===== hdl/mwo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oscillator package
// Shared widths, register indexes, waveform codes and types of the oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

	localparam int FREQ_W      = 23;
	localparam int OFFSET_W    = 15;
	localparam int GAIN_W      = 17;
	localparam int WAVE_W      = 2;
	localparam int OUT_W       = 16;
	localparam int SUM_W       = 24;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 17;
	localparam int QUEUE_DEPTH = 4;

	localparam int DEF_PHASE_BITS     = 32;
	localparam int DEF_SINE_ADDR_BITS = 10;
	localparam int DEF_SAMPLE_BITS    = 16;
	localparam int DEF_SAMPLE_RATE    = 48000;

	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 17'h10000;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WAVE   = 2'd2;

	localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd1;
	localparam logic [WAVE_W-1:0] WAVE_SAW      = 2'd2;
	localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd3;

	localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210, 64'd272};

	typedef struct packed {
		logic full;
		logic empty;
	} mwo_qstat_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [WAVE_W-1:0] wave;
	} mwo_cfg_t;

endpackage

// ===== hdl/mwo_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oscillator front end
// Adds the offset to each frequency word and turns the sum into a phase
// increment by a split reciprocal multiplication over three stages.
// ----------------------------------------------------------------------------
module mwo_front import mwo_pkg::*; #(
	parameter int PHASE_BITS  = DEF_PHASE_BITS,
	parameter int SAMPLE_RATE = DEF_SAMPLE_RATE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FREQ_W-1:0]     freq_hz,
	input  logic [OFFSET_W-1:0]   offset_hz,
	input  mwo_qstat_t            qstat,
	output logic                  push,
	output logic [PHASE_BITS-1:0] push_inc
);

	localparam int DIVISOR  = 256 * SAMPLE_RATE;
	localparam int DIV_W    = $clog2(DIVISOR + 1);
	localparam int SHIFT    = SUM_W + DIV_W;
	localparam int MUL_W    = PHASE_BITS + SUM_W + 2;
	localparam int MUL_LO_W = (MUL_W + 1) / 2;
	localparam int MUL_HI_W = MUL_W - MUL_LO_W;
	localparam int PROD_W   = SUM_W + MUL_W;
	localparam logic [127:0] RECIP = ((128'd1 << (PHASE_BITS + SHIFT)) +
		128'(DIVISOR) - 128'd1) / 128'(DIVISOR);
	localparam logic [MUL_LO_W-1:0] RECIP_LO = RECIP[MUL_LO_W-1:0];
	localparam logic [MUL_HI_W-1:0] RECIP_HI = RECIP[MUL_W-1:MUL_LO_W];

	logic                       adv;
	logic                       v_s1, v_s2, v_s3;
	logic [SUM_W-1:0]           sum_s1;
	logic [SUM_W+MUL_LO_W-1:0]  lo_s2;
	logic [SUM_W+MUL_HI_W-1:0]  hi_s2;
	logic [PROD_W-1:0]          prod;
	logic [PHASE_BITS-1:0]      inc_s3;

	assign adv      = !v_s3 || !qstat.full;
	assign in_ready = adv;
	assign push     = v_s3 && !qstat.full;
	assign push_inc = inc_s3;
	assign prod     = PROD_W'(lo_s2) + (PROD_W'(hi_s2) << MUL_LO_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= SUM_W'(freq_hz) + SUM_W'(offset_hz);
			lo_s2  <= (SUM_W+MUL_LO_W)'(sum_s1) * (SUM_W+MUL_LO_W)'(RECIP_LO);
			hi_s2  <= (SUM_W+MUL_HI_W)'(sum_s1) * (SUM_W+MUL_HI_W)'(RECIP_HI);
			inc_s3 <= prod[SHIFT +: PHASE_BITS];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && qstat.full) |-> !in_ready)
		else $error("Front end accepts a word while its last stage is blocked.");

endmodule

// ===== hdl/mwo_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Increment queue
// Short first-in first-out buffer of phase increments between the two halves.
// ----------------------------------------------------------------------------
module mwo_queue import mwo_pkg::*; #(
	parameter int WIDTH = DEF_PHASE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output mwo_qstat_t       qstat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign qstat.full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !qstat.full)
		else $error("Increment queue written while full.");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !qstat.empty)
		else $error("Increment queue read while empty.");

endmodule

// ===== hdl/mwo_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oscillator back end
// Holds the phase accumulator, forms the waveform, applies the gain and
// rounds and saturates the sample into the output register.
// ----------------------------------------------------------------------------
module mwo_back import mwo_pkg::*; #(
	parameter int PHASE_BITS     = DEF_PHASE_BITS,
	parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mwo_cfg_t              cfg,
	input  mwo_qstat_t            qstat,
	output logic                  pop,
	input  logic [PHASE_BITS-1:0] pop_inc,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_W-1:0]      sample_out
);

	localparam int ROM_N     = 1 << SINE_ADDR_BITS;
	localparam int ADDR_W    = SINE_ADDR_BITS + 1;
	localparam int PROD_W    = 50;
	localparam int SHIFT_OUT = 47 - SAMPLE_BITS;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SHIFT_OUT - 1);
	localparam logic signed [PROD_W-1:0] SAT_HI = (PROD_W'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam logic signed [PROD_W-1:0] SAT_LO = -(PROD_W'(1) << (SAMPLE_BITS - 1));
	localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

	typedef logic [30:0] sine_rom_t [0:ROM_N];

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x, x2, term;
		longint      acc;
		for (int i = 0; i <= ROM_N; i++) begin
			x    = (PIHALF_Q30 * 64'(i)) >> SINE_ADDR_BITS;
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			for (int k = 0; k < 8; k++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[k];
				if (k % 2 == 0) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			if (acc > longint'(Q30_ONE)) begin
				acc = longint'(Q30_ONE);
			end
			rom[i] = 31'(acc);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	logic                      adv;
	logic [PHASE_BITS-1:0]     phase_q;
	logic                      v_s1, v_s2, v_s3;
	logic [PHASE_BITS-1:0]     ph_s1;
	logic [1:0]                quad;
	logic [SINE_ADDR_BITS-1:0] idx;
	logic [ADDR_W-1:0]         rom_addr;
	logic [PHASE_BITS+29:0]    ph_ext;
	logic [29:0]               p30;
	logic signed [32:0]        tri_d, tri_abs, tri_val;
	logic signed [31:0]        lin;
	logic [30:0]               sine_s2;
	logic                      neg_s2, is_sine_s2;
	logic signed [31:0]        lin_s2;
	logic signed [31:0]        wave_val;
	logic signed [PROD_W-1:0]  wave_ext, gain_ext;
	logic signed [PROD_W-1:0]  prod_s3;
	logic signed [PROD_W-1:0]  rounded, res;
	logic                      out_valid_q;
	logic [OUT_W-1:0]          sample_q;

	assign adv        = !out_valid_q || out_ready;
	assign pop        = !qstat.empty && adv;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;

	always_comb begin
		quad     = ph_s1[PHASE_BITS-1 -: 2];
		idx      = ph_s1[PHASE_BITS-3 -: SINE_ADDR_BITS];
		rom_addr = quad[0] ? (ADDR_W'(ROM_N) - ADDR_W'(idx)) : ADDR_W'(idx);
		ph_ext   = {ph_s1, 30'b0};
		p30      = ph_ext[PHASE_BITS+29 -: 30];
		tri_d    = $signed({3'b000, p30}) - 33'sd536870912;
		tri_abs  = tri_d[32] ? -tri_d : tri_d;
		tri_val  = (tri_abs <<< 2) - 33'sd1073741824;
		case (cfg.wave)
			WAVE_SQUARE:   lin = ph_s1[PHASE_BITS-1] ? Q30_ONE : -Q30_ONE;
			WAVE_SAW:      lin = $signed({1'b0, p30, 1'b0}) - Q30_ONE;
			WAVE_TRIANGLE: lin = tri_val[31:0];
			default:       lin = '0;
		endcase
	end

	assign wave_val = is_sine_s2 ? (neg_s2 ? -$signed({1'b0, sine_s2}) : $signed({1'b0, sine_s2}))
		: lin_s2;
	assign wave_ext = {{(PROD_W-32){wave_val[31]}}, wave_val};
	assign gain_ext = {{(PROD_W-GAIN_W){1'b0}}, cfg.gain};
	assign rounded  = prod_s3 + ROUND_HALF;

	always_comb begin
		res = rounded >>> SHIFT_OUT;
		if (res > SAT_HI) begin
			res = SAT_HI;
		end
		if (res < SAT_LO) begin
			res = SAT_LO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && cfg.gain != '0) begin
				phase_q <= phase_q + pop_inc;
			end
			if (adv) begin
				v_s1        <= pop;
				v_s2        <= v_s1;
				v_s3        <= v_s2;
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s1      <= phase_q;
			sine_s2    <= SINE_ROM[rom_addr];
			neg_s2     <= quad[1];
			is_sine_s2 <= (cfg.wave == WAVE_SINE);
			lin_s2     <= lin;
			prod_s3    <= wave_ext * gain_ext;
			sample_q   <= res[OUT_W-1:0];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cfg.gain == '0) |=> $stable(phase_q))
		else $error("Phase moved on a word taken at zero gain.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s3 && cfg.gain == '0) |=> (sample_q == '0))
		else $error("Nonzero sample produced at zero gain.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!adv) |=> ($stable(v_s1) && $stable(v_s2) && $stable(v_s3)))
		else $error("Back end pipeline moved while the output was stalled.");

endmodule

// ===== hdl/multi_waveform_oscillator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-waveform oscillator
// Numerically controlled oscillator with sine, square, saw and triangle
// outputs, a frequency offset and an output gain.
//
//   Channel  Direction  Handshake            Contents
//   s_       in         s_tvalid/s_tready    tdata[22:0] freq_hz
//   m_       out        m_tvalid/m_tready    tdata[15:0] sample_out
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word is taken and one sample delivered per clock when the output is not
// stalled. A word passes the increment pipeline and then the queue; after it
// leaves the queue, its sample is formed in the back end stages s1, s2 and s3
// and then held in the output register.
// The increment queue holds four words, so the input side keeps running while
// the output is briefly stalled. Reset clears the phase and loads the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator import mwo_pkg::*; #(
	parameter int PHASE_BITS     = DEF_PHASE_BITS,
	parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
	parameter int SAMPLE_RATE    = DEF_SAMPLE_RATE
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [23:0]            s_tdata,   // [22:0] freq_hz
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata,   // [15:0] sample_out
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [OFFSET_W-1:0]   offset_q;
	logic [GAIN_W-1:0]     gain_q;
	logic [WAVE_W-1:0]     wave_q;
	mwo_cfg_t              cfg;
	mwo_qstat_t            qstat;
	logic                  push, pop;
	logic [PHASE_BITS-1:0] push_inc, pop_inc;

	assign cfg_ready = 1'b1;
	assign cfg.gain  = gain_q;
	assign cfg.wave  = wave_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
			gain_q   <= GAIN_RESET;
			wave_q   <= WAVE_SINE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OFFSET: offset_q <= cfg_data[OFFSET_W-1:0];
				REG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				REG_WAVE:   wave_q   <= cfg_data[WAVE_W-1:0];
				default: ;
			endcase
		end
	end

	mwo_front #(
		.PHASE_BITS  (PHASE_BITS),
		.SAMPLE_RATE (SAMPLE_RATE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.freq_hz   (s_tdata[FREQ_W-1:0]),
		.offset_hz (offset_q),
		.qstat     (qstat),
		.push      (push),
		.push_inc  (push_inc)
	);

	mwo_queue #(
		.WIDTH (PHASE_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_inc),
		.pop       (pop),
		.pop_data  (pop_inc),
		.qstat     (qstat)
	);

	mwo_back #(
		.PHASE_BITS     (PHASE_BITS),
		.SINE_ADDR_BITS (SINE_ADDR_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.qstat      (qstat),
		.pop        (pop),
		.pop_inc    (pop_inc),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.sample_out (m_tdata)
	);

endmodule
